// File: rtl/svmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svmc_pkg: shared types and constants
// Request and result layouts, operation codes, register map and reset values
// for the sample voice mixer with compressor.
// ----------------------------------------------------------------------------
package svmc_pkg;

  localparam int DEF_VOICES       = 10;
  localparam int DEF_SAMPLE_DEPTH = 65536;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_VOLUME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMPRESSOR_RISE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HISS_LEVEL        = 3'd5;

  localparam logic [16:0] RST_SAMPLE_LENGTH     = 17'd0;
  localparam logic [14:0] RST_START_VOLUME      = 15'd29491;
  localparam logic [15:0] RST_DECAY_FACTOR      = 16'd65532;
  localparam logic [14:0] RST_SILENCE_THRESHOLD = 15'd3;
  localparam logic [15:0] RST_COMPRESSOR_RISE   = 16'd7;
  localparam logic [14:0] RST_HISS_LEVEL        = 15'd10;

  localparam logic [23:0] GAIN_ONE   = 24'd65536;
  localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;
  localparam logic [31:0] LFSR_SEED  = 32'd1;
  localparam logic [31:0] LFSR_MASK  = 32'h80200003;
  localparam logic [14:0] OUT_SCALE  = 15'd32700;

  // mix accumulator, Q30, enough headroom for 32 voices plus hiss
  localparam int MIX_W  = 40;
  localparam int HALF_W = MIX_W / 2;
  localparam int QUO_W  = 47;

  typedef struct packed {
    logic [1:0]         operation;
    logic [23:0]        speed;
    logic [15:0]        pan;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_value;
  } item_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [3:0]         active_voices;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

// File: rtl/svmc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svmc_front: request intake
// Accepts requests, drops unused operation codes and holds up to two
// requests for the execution side.
// ----------------------------------------------------------------------------
module svmc_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  wire svmc_pkg::item_t item,
  output svmc_pkg::queue_head_t head,
  input  wire                  head_pop
);

  svmc_pkg::item_t entry [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == 2'd2);
  assign do_push  = push && !full && (item.operation != svmc_pkg::OP_NONE);
  assign do_pop   = head_pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// File: rtl/svmc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svmc_back: execution sequencer
// Holds configuration, sample memory and voices; runs sample writes,
// triggers and the per-tick mix, compressor and output scaling.
// ----------------------------------------------------------------------------
module svmc_back #(
  parameter int VOICES       = svmc_pkg::DEF_VOICES,
  parameter int SAMPLE_DEPTH = svmc_pkg::DEF_SAMPLE_DEPTH
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire [svmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [svmc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire svmc_pkg::queue_head_t          head,
  output logic                                head_pop,
  output logic                                empty,
  input  wire                                 pop,
  output svmc_pkg::result_t                   result
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int MW = svmc_pkg::MIX_W;
  localparam int HW = svmc_pkg::HALF_W;
  localparam int QW = svmc_pkg::QUO_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_HL   = 5'd1;
  localparam logic [4:0] S_HR   = 5'd2;
  localparam logic [4:0] S_V0   = 5'd3;
  localparam logic [4:0] S_V1   = 5'd4;
  localparam logic [4:0] S_V2   = 5'd5;
  localparam logic [4:0] S_V3   = 5'd6;
  localparam logic [4:0] S_GAIN = 5'd7;
  localparam logic [4:0] S_DIV  = 5'd8;
  localparam logic [4:0] S_CMP  = 5'd9;
  localparam logic [4:0] S_M0   = 5'd10;
  localparam logic [4:0] S_M1   = 5'd11;
  localparam logic [4:0] S_OUT  = 5'd12;
  localparam logic [4:0] S_DONE = 5'd13;

  // configuration
  logic [16:0] sample_length;
  logic [14:0] start_volume;
  logic [15:0] decay_factor;
  logic [14:0] silence_threshold;
  logic [15:0] compressor_rise;
  logic [14:0] hiss_level;

  // voices
  logic [31:0] pos   [VOICES];
  logic [23:0] spd   [VOICES];
  logic [14:0] vol   [VOICES];
  logic [15:0] vpan  [VOICES];
  logic [VOICES-1:0] active;
  logic [VW-1:0] nv;

  // sample memory
  logic [15:0] mem [SAMPLE_DEPTH];
  logic [15:0] mem_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // sequencer
  logic [4:0]  state;
  logic [VW-1:0] vi;
  logic [3:0]  count;
  logic [31:0] lfsr;
  logic [23:0] gain;
  logic signed [MW-1:0] acc_l;
  logic signed [MW-1:0] acc_r;
  logic        len_zero;
  logic        past_end;
  logic [29:0] mono_mag;
  logic        mono_neg;
  logic [MW-1:0] peak;
  logic [MW:0]   rem;
  logic [QW-1:0] quo;
  logic [5:0]    div_cnt;
  logic          ch;
  logic [2*HW+3:0] pp_lo;
  logic [30:0]   clamped;
  logic          out_neg;
  logic          out_valid;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  svmc_pkg::result_t res;

  // combinational helpers
  logic [31:0] lfsr_step;
  logic [30:0] hiss_prod;
  logic [32:0] pos_sum;
  logic [31:0] pos_new;
  logic [30:0] vol_prod;
  logic [14:0] vol_new;
  logic [15:0] idx;
  logic [16:0] rd_idx;
  logic signed [15:0] samp;
  logic [16:0] samp_mag;
  logic [31:0] mono_prod;
  logic [16:0] pan_w;
  logic [46:0] contrib_prod;
  logic [MW-1:0] contrib;
  logic [MW-1:0] mag_l;
  logic [MW-1:0] mag_r;
  logic [MW-1:0] mag;
  logic [24:0] gain_sum;
  logic [MW:0]   rem_s;
  logic          rem_ge;
  logic [2*HW+3:0] pp_hi;
  logic [63:0]   gsum;
  logic [47:0]   scaled;
  logic [45:0]   out_prod;
  logic [15:0]   out_mag;
  logic          voice_last;
  logic          start_ok;

  assign lfsr_step = (lfsr >> 1) ^ (lfsr[0] ? svmc_pkg::LFSR_MASK : 32'd0);
  assign hiss_prod = lfsr_step[15:0] * hiss_level;

  assign pos_sum  = {1'b0, pos[vi]} + {9'd0, spd[vi]};
  assign pos_new  = pos_sum[32] ? 32'hFFFFFFFF : pos_sum[31:0];
  assign vol_prod = vol[vi] * decay_factor;
  assign vol_new  = vol_prod[30:16];
  assign idx      = pos_new[31:16];
  assign rd_idx   = ({1'b0, idx} >= sample_length) ? (sample_length - 17'd1) : {1'b0, idx};
  assign rd_addr  = AW'({7'd0, rd_idx});
  assign wr_addr  = AW'({8'd0, head.item.sample_address});

  assign samp      = len_zero ? 16'sd0 : $signed(mem_q);
  assign samp_mag  = samp[15] ? (17'd0 - {1'b1, samp}) : {1'b0, samp};
  assign mono_prod = samp_mag * vol[vi];

  assign pan_w        = (state == S_V2) ? {1'b0, vpan[vi]} : (17'd65536 - {1'b0, vpan[vi]});
  assign contrib_prod = mono_mag * pan_w;
  assign contrib      = MW'(contrib_prod[46:16]);

  assign mag_l = acc_l[MW-1] ? MW'(-acc_l) : MW'(acc_l);
  assign mag_r = acc_r[MW-1] ? MW'(-acc_r) : MW'(acc_r);
  assign mag   = ch ? mag_r : mag_l;

  assign gain_sum = {1'b0, gain} + {9'd0, compressor_rise};

  assign rem_s  = {rem[MW-1:0], (div_cnt == 6'(QW - 1))};
  assign rem_ge = rem_s >= {1'b0, peak};

  assign pp_hi  = mag[MW-1:HW] * gain;
  assign gsum   = 64'(pp_lo) + (64'(pp_hi) << HW);
  assign scaled = gsum[63:16];

  assign out_prod = clamped * svmc_pkg::OUT_SCALE;
  assign out_mag  = out_prod[45:30];

  assign voice_last = (vi == VW'(VOICES - 1));
  assign start_ok   = (state == S_IDLE) && head.valid;
  assign head_pop   = start_ok;

  assign empty  = !out_valid;
  assign result = res;

  always_ff @(posedge clk) begin
    if (start_ok && head.item.operation == svmc_pkg::OP_WRITE) begin
      mem[wr_addr] <= head.item.sample_value;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_length     <= svmc_pkg::RST_SAMPLE_LENGTH;
      start_volume      <= svmc_pkg::RST_START_VOLUME;
      decay_factor      <= svmc_pkg::RST_DECAY_FACTOR;
      silence_threshold <= svmc_pkg::RST_SILENCE_THRESHOLD;
      compressor_rise   <= svmc_pkg::RST_COMPRESSOR_RISE;
      hiss_level        <= svmc_pkg::RST_HISS_LEVEL;
    end else if (cfg_write) begin
      case (cfg_index)
        svmc_pkg::REG_SAMPLE_LENGTH:     sample_length     <= cfg_data;
        svmc_pkg::REG_START_VOLUME:      start_volume      <= cfg_data[14:0];
        svmc_pkg::REG_DECAY_FACTOR:      decay_factor      <= cfg_data[15:0];
        svmc_pkg::REG_SILENCE_THRESHOLD: silence_threshold <= cfg_data[14:0];
        svmc_pkg::REG_COMPRESSOR_RISE:   compressor_rise   <= cfg_data[15:0];
        svmc_pkg::REG_HISS_LEVEL:        hiss_level        <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      nv        <= '0;
      vi        <= '0;
      count     <= 4'd0;
      lfsr      <= svmc_pkg::LFSR_SEED;
      gain      <= svmc_pkg::GAIN_ONE;
      out_valid <= 1'b0;
      ch        <= 1'b0;
      div_cnt   <= 6'd0;
      peak      <= '0;
    end else begin
      if (pop && out_valid && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start_ok) begin
            case (head.item.operation)
              svmc_pkg::OP_TRIGGER: begin
                pos[nv]    <= 32'd0;
                spd[nv]    <= head.item.speed;
                vol[nv]    <= start_volume;
                vpan[nv]   <= head.item.pan;
                active[nv] <= (head.item.speed != 24'd0);
                nv         <= (nv == VW'(VOICES - 1)) ? '0 : nv + VW'(1);
              end
              svmc_pkg::OP_TICK: state <= S_HL;
              default: ;
            endcase
          end
        end
        S_HL: begin
          lfsr  <= lfsr_step;
          acc_l <= MW'({hiss_prod[30:16], 15'd0});
          state <= S_HR;
        end
        S_HR: begin
          lfsr  <= lfsr_step;
          acc_r <= MW'({hiss_prod[30:16], 15'd0});
          vi    <= '0;
          count <= 4'd0;
          state <= S_V0;
        end
        S_V0: begin
          if (active[vi]) begin
            pos[vi]  <= pos_new;
            vol[vi]  <= vol_new;
            len_zero <= (sample_length == 17'd0);
            past_end <= ({1'b0, idx} >= sample_length);
            if (count != 4'd15) begin
              count <= count + 4'd1;
            end
            state <= S_V1;
          end else if (voice_last) begin
            state <= S_GAIN;
          end else begin
            vi <= vi + VW'(1);
          end
        end
        S_V1: begin
          mono_mag <= mono_prod[29:0];
          mono_neg <= samp[15];
          state    <= S_V2;
        end
        S_V2: begin
          acc_l <= mono_neg ? acc_l - $signed(contrib) : acc_l + $signed(contrib);
          state <= S_V3;
        end
        S_V3: begin
          acc_r <= mono_neg ? acc_r - $signed(contrib) : acc_r + $signed(contrib);
          if (vol[vi] < silence_threshold || past_end) begin
            active[vi] <= 1'b0;
          end
          if (voice_last) begin
            state <= S_GAIN;
          end else begin
            vi    <= vi + VW'(1);
            state <= S_V0;
          end
        end
        S_GAIN: begin
          gain    <= gain_sum[24] ? svmc_pkg::GAIN_MAX : gain_sum[23:0];
          peak    <= (mag_r > mag_l) ? mag_r : mag_l;
          rem     <= '0;
          quo     <= '0;
          div_cnt <= 6'(QW - 1);
          ch      <= 1'b0;
          state   <= (mag_l == '0 && mag_r == '0) ? S_M0 : S_DIV;
        end
        S_DIV: begin
          rem     <= rem_ge ? rem_s - {1'b0, peak} : rem_s;
          quo     <= {quo[QW-2:0], rem_ge};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd0) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (QW'(gain) > quo) begin
            gain <= quo[23:0];
          end
          state <= S_M0;
        end
        S_M0: begin
          pp_lo <= mag[HW-1:0] * gain;
          state <= S_M1;
        end
        S_M1: begin
          clamped <= (scaled > 48'd1073741824) ? 31'd1073741824 : scaled[30:0];
          out_neg <= ch ? acc_r[MW-1] : acc_l[MW-1];
          state   <= S_OUT;
        end
        S_OUT: begin
          if (ch) begin
            out_right <= out_neg ? -$signed(out_mag) : $signed(out_mag);
            state     <= S_DONE;
          end else begin
            out_left <= out_neg ? -$signed(out_mag) : $signed(out_mag);
            ch       <= 1'b1;
            state    <= S_M0;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            res.left          <= out_left;
            res.right         <= out_right;
            res.active_voices <= count;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_peak: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> peak != '0)
    else $error("divide started with zero peak");

  a_voice_idx: assert property (@(posedge clk) disable iff (rst)
    (int'(vi) < VOICES) && (int'(nv) < VOICES))
    else $error("voice index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && $stable(res))
    else $error("waiting result overwritten");

  a_gain_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_M0 |-> gain != 24'd0)
    else $error("compressor gain collapsed");

endmodule

`default_nettype wire

// File: rtl/sample_voice_mixer_compressor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_voice_mixer_compressor_core: polyphonic sampler with compressor
// Requests enter through a queue-style port: push with full, an item taken
// when push is high and full low. Write requests store a sample word, trigger
// requests start the next voice in round-robin order, tick requests produce
// one stereo frame on the result port (empty/pop, oldest frame shown while
// empty is low). Registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle, as the block
// itself does not enforce it. A write or trigger is handled in the idle
// state without leaving it. A tick adds hiss to both channels, mixes each
// playing voice through the one shared voice datapath, raises the gain by
// the rise step, divides for the peak limit (bit-serial, one quotient bit a
// cycle), lowers the gain to it and scales each channel; a silent mix skips
// the divide. Requests are handled one at a time; two more queue up in front.
// Reset stops all voices and sets the round-robin pointer, gain, noise state
// and registers to reset values; sample memory holds garbage until written.
// A finished frame waits in the result register while the receiver stalls;
// writes and triggers still proceed behind it, the next tick waits for the slot.
// ----------------------------------------------------------------------------
module sample_voice_mixer_compressor_core #(
  parameter int VOICES       = svmc_pkg::DEF_VOICES,
  parameter int SAMPLE_DEPTH = svmc_pkg::DEF_SAMPLE_DEPTH
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            push,
  output logic                           full,
  input  wire svmc_pkg::item_t           item,
  output logic                           empty,
  input  wire                            pop,
  output svmc_pkg::result_t              result,
  input  wire                            cfg_write,
  input  wire [svmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [svmc_pkg::CFG_DATA_W-1:0] cfg_data
);

  svmc_pkg::queue_head_t head;
  logic                  head_pop;

  svmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .head     (head),
    .head_pop (head_pop)
  );

  svmc_back #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .head_pop  (head_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire
